FILE: rtl/core/sphenic_number_test_top_defines.svh
// assertion macros shared by the rtl
`ifndef SPHENIC_NUMBER_TEST_TOP_DEFINES_SVH
`define SPHENIC_NUMBER_TEST_TOP_DEFINES_SVH

// concurrent assertion on a given clock and active-low reset
`define SPNT_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define SPNT_ASSERT(label, prop, msg) `SPNT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/spnt_pkg.sv
package spnt_pkg;

  // input word width and divider step counter width
  localparam int unsigned NUM_W = 32;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // default table size
  localparam int unsigned SIEVE_LIMIT_DEF = 65536;
  localparam int unsigned DIV_W_DEF       = $clog2(SIEVE_LIMIT_DEF + 1);

  // factor counting
  localparam int unsigned FC_W        = 3;
  localparam int unsigned FACTORS     = 3;
  localparam int unsigned FIRST_PRIME = 2;

  typedef enum logic [3:0] {
    S_CLR,
    S_SV_RD,
    S_SV_CHK,
    S_SV_MARK,
    S_IDLE,
    S_TOP,
    S_MAP,
    S_DIV,
    S_OUT
  } spnt_state_e;

endpackage

FILE: rtl/core/spnt_if.sv
// number channel
interface spnt_in_if import spnt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

// result channel
interface spnt_out_if;
  logic valid;
  logic ready;
  logic is_sphenic;

  modport source (output valid, output is_sphenic, input ready);
  modport sink   (input valid, input is_sphenic, output ready);
endinterface

FILE: rtl/core/spnt_div.sv
module spnt_div import spnt_pkg::*; #(
  parameter int unsigned DIV_W = DIV_W_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o,
  output logic [DIV_W-1:0] remainder_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] prem_q, prem_d;
  logic [DIV_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;
  logic             fits;

  // one restoring step: bring down the next dividend bit
  assign shifted = {prem_q, quo_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    prem_d = prem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      prem_d = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = {quo_q[NUM_W-2:0], fits};
      prem_d = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    prem_q <= prem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = prem_q;

endmodule

FILE: rtl/core/sphenic_number_test_top.sv
// after reset: the table is cleared, then the sieve marking pass strikes the multiples
//   of each base whose square is below SIEVE_LIMIT before the input is ready
// per number: each trial candidate is read from the table, and each prime candidate is
//   tried by the bit-serial divider, with one more division for each factor found
// one number in flight at a time; the result waits in an output register until taken
// reset: asynchronous active low, clears control state and restarts the table fill
`include "sphenic_number_test_top_defines.svh"

module sphenic_number_test_top import spnt_pkg::*; #(
  parameter int unsigned SIEVE_LIMIT = SIEVE_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spnt_in_if.sink    num_i,
  spnt_out_if.source res_o
);

  localparam int unsigned ADDR_W = $clog2(SIEVE_LIMIT);
  localparam int unsigned DIV_W  = $clog2(SIEVE_LIMIT + 1);
  localparam int unsigned SQ_W   = 2 * DIV_W;
  localparam int unsigned CMP_W  = (SQ_W > NUM_W) ? SQ_W : NUM_W;

  spnt_state_e state_q, state_d;

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dv_q, dv_d;
  logic [FC_W-1:0]   fc_q, fc_d;
  logic [ADDR_W-1:0] p_q, p_d;
  logic [DIV_W-1:0]  m_q, m_d;
  logic              pass_q, pass_d;
  logic              res_q, res_d;

  logic [DIV_W-1:0]  mul_a;
  logic [SQ_W-1:0]   sq;
  logic [DIV_W:0]    m_sum;
  logic              sq_over;
  logic              mark_end;
  logic              clr_end;
  logic              top_hit;
  logic              top_miss;
  logic              top_last;
  logic              top_done;

  logic              map_mem [SIEVE_LIMIT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic              mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic              map_rd_q;

  logic              div_start;
  logic [NUM_W-1:0]  div_dividend;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [DIV_W-1:0]  div_rem;
  logic              div_zero;

  // shared squarer: sieve base while building, trial divisor while testing
  assign mul_a = (state_q == S_SV_RD || state_q == S_SV_CHK) ? DIV_W'(p_q) : dv_q;
  assign sq    = SQ_W'(mul_a) * SQ_W'(mul_a);

  // sieve progress
  assign sq_over  = sq >= SQ_W'(SIEVE_LIMIT);
  assign m_sum    = (DIV_W + 1)'(m_q) + (DIV_W + 1)'(p_q);
  assign mark_end = m_sum >= (DIV_W + 1)'(SIEVE_LIMIT);
  assign clr_end  = m_q == DIV_W'(SIEVE_LIMIT - 1);

  // trial loop exits; once the candidate squared passes the remainder, the remainder is prime
  assign top_hit  = (fc_q == FC_W'(FACTORS)) && (rem_q == NUM_W'(1));
  assign top_miss = (fc_q > FC_W'(FACTORS)) || (dv_q >= DIV_W'(SIEVE_LIMIT)) ||
                    (rem_q == NUM_W'(1));
  assign top_last = CMP_W'(sq) > CMP_W'(rem_q);
  assign top_done = top_hit || top_miss || top_last;

  assign div_zero = div_rem == '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:     if (clr_end) state_d = S_SV_RD;
      S_SV_RD:   state_d = sq_over ? S_IDLE : S_SV_CHK;
      S_SV_CHK:  state_d = map_rd_q ? S_SV_MARK : S_SV_RD;
      S_SV_MARK: if (mark_end) state_d = S_SV_RD;
      S_IDLE: begin
        if (num_i.valid) state_d = (num_i.number < NUM_W'(FIRST_PRIME)) ? S_OUT : S_TOP;
      end
      S_TOP:     state_d = top_done ? S_OUT : S_MAP;
      S_MAP:     state_d = map_rd_q ? S_DIV : S_TOP;
      S_DIV: begin
        if (div_done) begin
          if (!div_zero) state_d = S_TOP;
          else if (pass_q) state_d = S_OUT;
        end
      end
      S_OUT:     if (res_o.ready) state_d = S_IDLE;
      default:   state_d = S_CLR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    rem_d        = rem_q;
    dv_d         = dv_q;
    fc_d         = fc_q;
    p_d          = p_q;
    m_d          = m_q;
    pass_d       = pass_q;
    res_d        = res_q;
    mem_we       = 1'b0;
    mem_wa       = m_q[ADDR_W-1:0];
    mem_wd       = 1'b0;
    mem_re       = 1'b0;
    mem_ra       = p_q;
    div_start    = 1'b0;
    div_dividend = rem_q;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wd = m_q >= DIV_W'(FIRST_PRIME);
        m_d    = m_q + DIV_W'(1);
      end
      S_SV_RD: begin
        mem_re = !sq_over;
      end
      S_SV_CHK: begin
        if (map_rd_q) m_d = sq[DIV_W-1:0];
        else p_d = p_q + ADDR_W'(1);
      end
      S_SV_MARK: begin
        mem_we = 1'b1;
        if (mark_end) p_d = p_q + ADDR_W'(1);
        else m_d = m_sum[DIV_W-1:0];
      end
      S_IDLE: begin
        rem_d = num_i.number;
        dv_d  = DIV_W'(FIRST_PRIME);
        fc_d  = '0;
        res_d = 1'b0;
      end
      S_TOP: begin
        mem_re = !top_done;
        mem_ra = dv_q[ADDR_W-1:0];
        if (top_hit) res_d = 1'b1;
        else if (top_miss) res_d = 1'b0;
        else if (top_last) res_d = (rem_q < NUM_W'(SIEVE_LIMIT)) &&
                                   (fc_q == FC_W'(FACTORS - 1));
      end
      S_MAP: begin
        if (map_rd_q) begin
          div_start = 1'b1;
          pass_d    = 1'b0;
        end else begin
          dv_d = dv_q + DIV_W'(1);
        end
      end
      S_DIV: begin
        div_dividend = div_quo;
        if (div_done) begin
          if (!div_zero) begin
            dv_d = dv_q + DIV_W'(1);
          end else if (pass_q) begin
            res_d = 1'b0;
          end else begin
            // factor found on the first division: divide it out and check for a repeat
            rem_d     = div_quo;
            fc_d      = fc_q + FC_W'(1);
            pass_d    = 1'b1;
            div_start = 1'b1;
          end
        end
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // handshake outputs
  always_comb begin
    num_i.ready      = state_q == S_IDLE;
    res_o.valid      = state_q == S_OUT;
    res_o.is_sphenic = res_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      p_q     <= ADDR_W'(FIRST_PRIME);
      m_q     <= '0;
      pass_q  <= 1'b0;
      fc_q    <= '0;
      dv_q    <= DIV_W'(FIRST_PRIME);
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      m_q     <= m_d;
      pass_q  <= pass_d;
      fc_q    <= fc_d;
      dv_q    <= dv_d;
      rem_q   <= rem_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // prime table, one read port and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    if (mem_re) map_rd_q <= map_mem[mem_ra];
  end

  spnt_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (dv_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  `SPNT_ASSERT(a_one_item, !(num_i.ready && res_o.valid), "input open while result pending")
  `SPNT_ASSERT(a_div_owner, div_done |-> (state_q == S_DIV), "divider finished outside trial")
  `SPNT_ASSERT(a_fc_bound, fc_q <= FC_W'(FACTORS + 1), "factor count past four")

endmodule
